// ===== design/cass_pkg.sv =====
// ----------------------------------------------------------------------------
// cass_pkg: shared types and helpers for the cigar span summary
// Op codes, counter bank type and saturating adders.
// ----------------------------------------------------------------------------
`default_nettype none

package cass_pkg;

   localparam int LEN_BITS = 28;
   localparam int SUM_BITS = 32;
   localparam int REF_BITS = 31;
   localparam int OP_BITS  = 4;
   localparam int SUM_EXT  = SUM_BITS + 2;

   typedef enum logic [OP_BITS-1:0] {
      OP_M  = 4'd0,
      OP_I  = 4'd1,
      OP_D  = 4'd2,
      OP_N  = 4'd3,
      OP_S  = 4'd4,
      OP_H  = 4'd5,
      OP_P  = 4'd6,
      OP_EQ = 4'd7,
      OP_X  = 4'd8,
      OP_B  = 4'd9
   } op_code_type;

   typedef struct packed {
      logic [SUM_BITS-1:0] match_total;
      logic [SUM_BITS-1:0] mismatches;
      logic [SUM_BITS-1:0] inserts;
      logic [SUM_BITS-1:0] deletes;
      logic [SUM_BITS-1:0] skips;
      logic [LEN_BITS-1:0] head_clip;
      logic [LEN_BITS-1:0] tail_clip;
   } sums_type;

   function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] a,
                                                   input logic [LEN_BITS-1:0] b);
      logic [SUM_BITS:0] s;
      s = {1'b0, a} + {{(SUM_BITS - LEN_BITS + 1){1'b0}}, b};
      return s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
   endfunction

   // saturating sum of four terms; saturation is sticky, so one clamp suffices
   function automatic logic [SUM_BITS-1:0] sat_sum4(input logic [SUM_BITS-1:0] a,
                                                    input logic [SUM_BITS-1:0] b,
                                                    input logic [SUM_BITS-1:0] c,
                                                    input logic [SUM_BITS-1:0] d);
      logic [SUM_EXT-1:0] s;
      s = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
      return (|s[SUM_EXT-1:SUM_BITS]) ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/cigar_alignment_span_summary.sv =====
// ----------------------------------------------------------------------------
// cigar_alignment_span_summary: per-alignment cigar statistics
// Sums cigar op lengths per class and reports spans on the last op.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one cigar op per beat. tuser[0] marks the first op of an
//   alignment (clears the counters), tlast marks the last op (emits a
//   result). ref_begin and reverse_strand are sampled on the last op.
//   rsp_* carries one summary beat per alignment.
//   Throughput: one op per cycle, sustained, with rsp_tready high.
//   Path: a last op passes through the input register, the counter
//   update and snapshot stage, then the span adder and result register,
//   before its result shows on rsp.
//   Reset clears the counters and empties every stage.
//   When rsp_tready is low the result register holds; ops that are not
//   last keep flowing into the counters, and the first last op that finds
//   the snapshot stage full holds in the input register until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module cigar_alignment_span_summary (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // op_code[3:0], op_length[31:4], ref_begin[62:32], zero[63]
   input  wire logic [63:0]  req_tdata,
   // first_op[0], reverse_strand[1]
   input  wire logic [1:0]   req_tuser,
   input  wire logic         req_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // matches_res[31:0], mismatches[63:32], inserts[95:64], deletes[127:96],
   // skips[159:128], ref_end[191:160], query_begin[219:192],
   // query_end[251:220], zero[255:252]
   output logic [255:0]      rsp_tdata
);

   logic                            a_valid_ff;
   logic [cass_pkg::OP_BITS-1:0]    a_op_ff;
   logic [cass_pkg::LEN_BITS-1:0]   a_len_ff;
   logic [cass_pkg::REF_BITS-1:0]   a_rbeg_ff;
   logic                            a_first_ff;
   logic                            a_last_ff;
   logic                            a_rev_ff;

   logic                            b_valid_ff;
   cass_pkg::sums_type              b_sums_ff;
   logic [cass_pkg::REF_BITS-1:0]   b_rbeg_ff;
   logic [cass_pkg::LEN_BITS-1:0]   b_qbeg_ff;

   logic                            c_valid_ff;
   logic [255:0]                    c_data_ff;

   cass_pkg::sums_type              sums_in;
   logic [cass_pkg::SUM_BITS-1:0]   ref_end;
   logic [cass_pkg::SUM_BITS-1:0]   query_end;
   logic [255:0]                    c_data_in;
   logic                            c_load;
   logic                            b_free;
   logic                            a_adv;

   assign c_load     = b_valid_ff && (!c_valid_ff || rsp_tready);
   assign b_free     = !b_valid_ff || c_load;
   assign a_adv      = a_valid_ff && (!a_last_ff || b_free);
   assign req_tready = !a_valid_ff || a_adv;

   cass_counters u_counters (
      .clock     (clock),
      .reset     (reset),
      .update    (a_adv),
      .op_code   (cass_pkg::op_code_type'(a_op_ff)),
      .op_length (a_len_ff),
      .first_op  (a_first_ff),
      .sums_in   (sums_in)
   );

   always_comb begin
      ref_end   = cass_pkg::sat_sum4(
                     {{(cass_pkg::SUM_BITS - cass_pkg::REF_BITS){1'b0}}, b_rbeg_ff},
                     b_sums_ff.match_total, b_sums_ff.mismatches, b_sums_ff.deletes);
      query_end = cass_pkg::sat_sum4(
                     {{(cass_pkg::SUM_BITS - cass_pkg::LEN_BITS){1'b0}}, b_qbeg_ff},
                     b_sums_ff.match_total, b_sums_ff.mismatches, b_sums_ff.inserts);
      c_data_in = {4'b0000, query_end, b_qbeg_ff, ref_end, b_sums_ff.skips,
                   b_sums_ff.deletes, b_sums_ff.inserts, b_sums_ff.mismatches,
                   b_sums_ff.match_total};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            a_valid_ff <= req_tvalid;
         end
         if (b_free) begin
            b_valid_ff <= a_adv && a_last_ff;
         end
         if (c_load) begin
            c_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            c_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         a_op_ff    <= req_tdata[3:0];
         a_len_ff   <= req_tdata[31:4];
         a_rbeg_ff  <= req_tdata[62:32];
         a_first_ff <= req_tuser[0];
         a_rev_ff   <= req_tuser[1];
         a_last_ff  <= req_tlast;
      end
      if (a_adv && a_last_ff && b_free) begin
         b_sums_ff <= sums_in;
         b_rbeg_ff <= a_rbeg_ff;
         b_qbeg_ff <= a_rev_ff ? sums_in.tail_clip : sums_in.head_clip;
      end
      if (c_load) begin
         c_data_ff <= c_data_in;
      end
   end

   assign rsp_tvalid = c_valid_ff;
   assign rsp_tdata  = c_data_ff;

`ifndef SYNTHESIS
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> a_valid_ff)
      else $error("accepted beat did not reach the input register");

   a_last_holds: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && a_last_ff && !b_free |=> a_valid_ff && a_last_ff)
      else $error("last op dropped while snapshot stage was full");

   b_to_c: assert property (@(posedge clock) disable iff (reset)
      c_load |=> rsp_tvalid)
      else $error("snapshot loaded but no result presented");

   qend_ge_qbeg: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[251:220] >= {4'b0000, rsp_tdata[219:192]})
      else $error("query end below query begin");

   rend_ge_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[191:160] >= rsp_tdata[31:0])
      else $error("reference end below match count");
`endif

endmodule

`default_nettype wire

// ===== design/cass_counters.sv =====
// ----------------------------------------------------------------------------
// cass_counters: cigar op counter bank
// Saturating length sums per op class plus head and tail clip capture.
// ----------------------------------------------------------------------------
`default_nettype none

module cass_counters (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          update,
   input  wire cass_pkg::op_code_type         op_code,
   input  wire logic [cass_pkg::LEN_BITS-1:0] op_length,
   input  wire logic                          first_op,
   output cass_pkg::sums_type                 sums_in
);

   cass_pkg::sums_type sums_ff;
   cass_pkg::sums_type base;

   always_comb begin
      base    = first_op ? '0 : sums_ff;
      sums_in = base;
      case (op_code)
         cass_pkg::OP_M, cass_pkg::OP_EQ: begin
            sums_in.match_total = cass_pkg::sat_add(base.match_total, op_length);
         end
         cass_pkg::OP_X: begin
            sums_in.mismatches = cass_pkg::sat_add(base.mismatches, op_length);
         end
         cass_pkg::OP_I: begin
            sums_in.inserts = cass_pkg::sat_add(base.inserts, op_length);
         end
         cass_pkg::OP_D: begin
            sums_in.deletes = cass_pkg::sat_add(base.deletes, op_length);
         end
         cass_pkg::OP_N: begin
            sums_in.skips = cass_pkg::sat_add(base.skips, op_length);
         end
         cass_pkg::OP_S, cass_pkg::OP_H: begin
            if (first_op) begin
               sums_in.head_clip = op_length;
            end else begin
               sums_in.tail_clip = op_length;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sums_ff <= '0;
      end else if (update) begin
         sums_ff <= sums_in;
      end
   end

endmodule

`default_nettype wire
